FILE: src/websocket_frame_deframer_assert.svh
// assertion macros for the frame deframer
// expects clk and rst_n in the scope where a macro is used
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg)
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/wsfd_pkg.sv
// types and constants shared by the frame deframer
// no dependencies
package wsfd_pkg;

  localparam int unsigned CONTROL_MAX = 125;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2048;

  localparam logic [7:0] HDR0_RSV_MASK = 8'h70;
  localparam logic [7:0] HDR_TOP_BIT   = 8'h80;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_EMPTY      = 2'd1,
    KIND_ERROR      = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RSV       = 3'd0,
    ERR_UNMASKED  = 3'd1,
    ERR_FRAGMENT  = 3'd2,
    ERR_OPCODE    = 3'd3,
    ERR_TOO_LONG  = 3'd4,
    ERR_CTRL_LONG = 3'd5,
    ERR_CLOSE_ONE = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic       go;
    logic [7:0] rx_byte;
    logic       buffer_start;
  } xfer_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       last;
    err_t       error_code;
  } result_t;

  typedef struct packed {
    phase_t phase;
  } status_t;

endpackage

FILE: src/wsfd_in_if.sv
// input byte channel of the frame deframer
// no dependencies
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;

  modport source (output valid, output rx_byte, output buffer_start, input ready);
  modport sink (input valid, input rx_byte, input buffer_start, output ready);
endinterface

FILE: src/wsfd_out_if.sv
// result channel of the frame deframer
// depends on wsfd_pkg
interface wsfd_out_if;
  logic               valid;
  logic               ready;
  wsfd_pkg::kind_t    kind;
  logic [7:0]         payload_byte;
  logic [3:0]         frame_opcode;
  logic               last;
  wsfd_pkg::err_t     error_code;

  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output last, output error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                input last, input error_code, output ready);
endinterface

FILE: src/wsfd_parser.sv
// frame parser state and per-byte next-state logic
// depends on wsfd_pkg
module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       max_payload,
  input  wsfd_pkg::xfer_t   xfer,
  output logic              res_valid,
  output wsfd_pkg::result_t res,
  output wsfd_pkg::status_t st
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;

  logic [63:0] len_cand;
  logic        len_final;
  logic        too_long;
  logic        is_control;
  logic [3:0]  hidx_inc;
  logic [7:0]  key_byte;
  logic        is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hidx_r   <= '0;
      opcode_r <= '0;
      len_r    <= '0;
      mask_r   <= '0;
      pidx_r   <= '0;
      hdr0_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      opcode_r <= opcode_nxt;
      len_r    <= len_nxt;
      mask_r   <= mask_nxt;
      pidx_r   <= pidx_nxt;
      hdr0_r   <= hdr0_nxt;
    end
  end

  assign is_control = (opcode_r == OP_CLOSE) || (opcode_r == OP_PING) || (opcode_r == OP_PONG);
  assign too_long   = (|len_cand[63:16]) || (len_cand[15:0] > max_payload);
  assign hidx_inc   = hidx_r + 4'd1;
  assign is_last    = (len_r[63:17] == '0) && ((17'(pidx_r) + 17'd1) == len_r[16:0]);

  always_comb begin
    unique case (pidx_r[1:0])
      2'd0: key_byte = mask_r[31:24];
      2'd1: key_byte = mask_r[23:16];
      2'd2: key_byte = mask_r[15:8];
      2'd3: key_byte = mask_r[7:0];
      default: key_byte = '0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    opcode_nxt = opcode_r;
    len_nxt    = len_r;
    mask_nxt   = mask_r;
    pidx_nxt   = pidx_r;
    hdr0_nxt   = hdr0_r;
    len_cand   = len_r;
    len_final  = 1'b0;
    res_valid  = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.frame_opcode = opcode_r;
    res.last         = 1'b0;
    res.error_code   = ERR_RSV;

    if (xfer.go) begin
      if (xfer.buffer_start) begin
        if (phase_r != PH_IDLE) begin
          res_valid = 1'b1;
          res.kind  = KIND_INCOMPLETE;
        end
        hdr0_nxt   = xfer.rx_byte;
        opcode_nxt = xfer.rx_byte[3:0];
        len_nxt    = '0;
        hidx_nxt   = '0;
        mask_nxt   = '0;
        pidx_nxt   = '0;
        phase_nxt  = PH_HDR1;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_HDR1: begin
            priority if ((hdr0_r & HDR0_RSV_MASK) != '0) begin
              res_valid = 1'b1;
              res.error_code = ERR_RSV;
            end else if ((xfer.rx_byte & HDR_TOP_BIT) == '0) begin
              res_valid = 1'b1;
              res.error_code = ERR_UNMASKED;
            end else if (((hdr0_r & HDR_TOP_BIT) == '0) || (opcode_r == OP_CONT)) begin
              res_valid = 1'b1;
              res.error_code = ERR_FRAGMENT;
            end else if ((opcode_r != OP_TEXT) && (opcode_r != OP_BINARY) &&
                         (opcode_r != OP_CLOSE) && (opcode_r != OP_PING) &&
                         (opcode_r != OP_PONG)) begin
              res_valid = 1'b1;
              res.error_code = ERR_OPCODE;
            end else if (xfer.rx_byte[6:0] == LEN7_EXT16) begin
              len_nxt   = '0;
              hidx_nxt  = EXT16_BYTES;
              phase_nxt = PH_EXTLEN;
            end else if (xfer.rx_byte[6:0] == LEN7_EXT64) begin
              len_nxt   = '0;
              hidx_nxt  = EXT64_BYTES;
              phase_nxt = PH_EXTLEN;
            end else begin
              len_cand  = 64'(xfer.rx_byte[6:0]);
              len_nxt   = len_cand;
              len_final = 1'b1;
            end
            if (res_valid) begin
              res.kind  = KIND_ERROR;
              phase_nxt = PH_IDLE;
            end
          end
          PH_EXTLEN: begin
            len_cand  = {len_r[55:0], xfer.rx_byte};
            len_nxt   = len_cand;
            hidx_nxt  = hidx_r - 4'd1;
            len_final = (hidx_r == 4'd1);
          end
          PH_MASK: begin
            mask_nxt = {mask_r[23:0], xfer.rx_byte};
            hidx_nxt = hidx_inc;
            if (hidx_inc >= MASK_BYTES) begin
              pidx_nxt = '0;
              if (len_r == '0) begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.last  = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            pidx_nxt  = pidx_r + 16'd1;
            res_valid = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.payload_byte = xfer.rx_byte ^ key_byte;
            res.last  = is_last;
            if (is_last) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase

        if (len_final) begin
          priority if (too_long) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
            phase_nxt = PH_IDLE;
          end else if (is_control && (len_cand[15:0] > 16'(CONTROL_MAX))) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_CTRL_LONG;
            phase_nxt = PH_IDLE;
          end else if ((opcode_r == OP_CLOSE) && (len_cand[15:0] == 16'd1)) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_CLOSE_ONE;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_MASK;
            hidx_nxt  = '0;
            mask_nxt  = '0;
          end
        end
      end
    end
  end

  assign st.phase = phase_r;

endmodule

FILE: src/websocket_frame_deframer.sv
// websocket client frame deframer top level: input register, parser, result register
// each accepted byte waits in the input register until the result register is free, then its result is registered there
// throughput: one byte per cycle unless the result register stalls, set by the single register-to-register parse step
// a stalled result register holds the input register, which then drops ready
// reset (rst_n low, synchronous) clears the parser to idle and max_payload to 2048
// depends on wsfd_pkg, wsfd_in_if, wsfd_out_if, wsfd_parser and the assertion header
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  wsfd_in_if.sink     in_ch,
  wsfd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import wsfd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        out_valid_r;
  result_t     out_res_r;
  logic [15:0] max_payload_r;

  logic        advance;
  xfer_t       xfer;
  logic        res_valid;
  result_t     res;
  status_t     st;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r  <= in_ch.rx_byte;
      in_start_r <= in_ch.buffer_start;
    end
  end

  assign xfer.go           = advance;
  assign xfer.rx_byte      = in_byte_r;
  assign xfer.buffer_start = in_start_r;

  wsfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_payload (max_payload_r),
    .xfer        (xfer),
    .res_valid   (res_valid),
    .res         (res),
    .st          (st)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.frame_opcode = out_res_r.frame_opcode;
  assign out_ch.last         = out_res_r.last;
  assign out_ch.error_code   = out_res_r.error_code;

  `WSFD_ASSERT_NXT(a_in_hold, in_valid_r && !advance, in_valid_r && $stable(in_byte_r), "input register lost a byte")
  `WSFD_ASSERT_NXT(a_err_idle, advance && res_valid && (res.kind == KIND_ERROR), st.phase == PH_IDLE, "parser not idle after error")
  `WSFD_ASSERT_NXT(a_last_idle, advance && res_valid && res.last, st.phase == PH_IDLE, "parser not idle after last")
  `WSFD_ASSERT_NXT(a_start_hdr, advance && in_start_r, st.phase == PH_HDR1, "buffer start did not restart header")

endmodule

FILE: test/testbench.sv
// testbench for websocket_frame_deframer: byte stream in, payload and status results out
// predicts every result with a scoreboard class and checks each one in order
// depends on wsfd_pkg, wsfd_in_if, wsfd_out_if and the deframer rtl
`timescale 1ns / 100ps

module testbench;
  import wsfd_pkg::*;

  // error field reads zero outside protocol errors
  localparam err_t NO_ERR = ERR_RSV;

  class frame_scoreboard;
    result_t     pending_results[$];
    int          errors;
    int          parsed_bytes;
    logic [15:0] max_payload;
    phase_t      phase;
    logic [3:0]  hdr_index;
    logic [3:0]  opcode;
    logic [63:0] length;
    logic [31:0] mask_key;
    logic [15:0] pay_index;
    logic [7:0]  hdr0;

    function new();
      errors = 0;
      parsed_bytes = 0;
      max_payload = MAX_PAYLOAD_RST;
      phase = PH_IDLE;
      hdr_index = '0;
      opcode = '0;
      length = '0;
      mask_key = '0;
      pay_index = '0;
      hdr0 = '0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push(kind_t k, logic [7:0] b, logic l, err_t ec);
      result_t r;
      r.kind = k;
      r.payload_byte = b;
      r.frame_opcode = opcode;
      r.last = l;
      r.error_code = ec;
      pending_results.push_back(r);
    endfunction

    function void protocol_error(err_t ec);
      phase = PH_IDLE;
      push(KIND_ERROR, 8'h00, 1'b0, ec);
    endfunction

    function void length_rules();
      logic ctrl;
      ctrl = opcode inside {OP_CLOSE, OP_PING, OP_PONG};
      if (length > {48'd0, max_payload}) begin
        protocol_error(ERR_TOO_LONG);
      end else if (ctrl && length > CONTROL_MAX) begin
        protocol_error(ERR_CTRL_LONG);
      end else if (opcode == OP_CLOSE && length == 64'd1) begin
        protocol_error(ERR_CLOSE_ONE);
      end else begin
        phase = PH_MASK;
        hdr_index = '0;
        mask_key = '0;
      end
    endfunction

    function void parse_byte(logic [7:0] b, logic start);
      logic [6:0] len7;
      logic [7:0] key;
      logic       fin_byte;
      len7 = b[6:0];
      parsed_bytes++;
      if (start) begin
        if (phase != PH_IDLE) push(KIND_INCOMPLETE, 8'h00, 1'b0, NO_ERR);
        hdr0 = b;
        opcode = b[3:0];
        length = '0;
        hdr_index = '0;
        mask_key = '0;
        pay_index = '0;
        phase = PH_HDR1;
        return;
      end
      case (phase)
        PH_HDR1: begin
          if ((hdr0 & HDR0_RSV_MASK) != 8'h00) protocol_error(ERR_RSV);
          else if ((b & HDR_TOP_BIT) == 8'h00) protocol_error(ERR_UNMASKED);
          else if ((hdr0 & HDR_TOP_BIT) == 8'h00 || opcode == OP_CONT)
            protocol_error(ERR_FRAGMENT);
          else if (!(opcode inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
            protocol_error(ERR_OPCODE);
          else begin
            length = '0;
            if (len7 == LEN7_EXT16) begin
              hdr_index = EXT16_BYTES;
              phase = PH_EXTLEN;
            end else if (len7 == LEN7_EXT64) begin
              hdr_index = EXT64_BYTES;
              phase = PH_EXTLEN;
            end else begin
              length = {57'd0, len7};
              length_rules();
            end
          end
        end
        PH_EXTLEN: begin
          length = {length[55:0], b};
          hdr_index = hdr_index - 4'd1;
          if (hdr_index == 4'd0) length_rules();
        end
        PH_MASK: begin
          mask_key = {mask_key[23:0], b};
          hdr_index = hdr_index + 4'd1;
          if (hdr_index == MASK_BYTES) begin
            pay_index = '0;
            if (length == 64'd0) begin
              phase = PH_IDLE;
              push(KIND_EMPTY, 8'h00, 1'b1, NO_ERR);
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          key = 8'(mask_key >> (8 * (3 - pay_index[1:0])));
          fin_byte = ({48'd0, pay_index} + 64'd1 == length);
          pay_index = pay_index + 16'd1;
          if (fin_byte) phase = PH_IDLE;
          push(KIND_PAYLOAD, b ^ key, fin_byte, NO_ERR);
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    task check_result(kind_t k, logic [7:0] pb, logic [3:0] op, logic l, err_t ec);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with none expected: kind %0d byte %02h", k, pb));
        return;
      end
      want = pending_results.pop_front();
      if (k !== want.kind)
        report($sformatf("kind got %0d expected %0d", k, want.kind));
      if (pb !== want.payload_byte)
        report($sformatf("payload_byte got %02h expected %02h", pb, want.payload_byte));
      if (op !== want.frame_opcode)
        report($sformatf("frame_opcode got %0d expected %0d", op, want.frame_opcode));
      if (l !== want.last)
        report($sformatf("last got %0d expected %0d", l, want.last));
      if (ec !== want.error_code)
        report($sformatf("error_code got %0d expected %0d", ec, want.error_code));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  wsfd_in_if  in_if();
  wsfd_out_if out_if();

  websocket_frame_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  int              burst_left;
  int              stall_mode;
  int              stall_left;
  int              stall_tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stalls in stretches of changing character
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left = stall_left - 1;
    end
    stall_tick = stall_tick + 1;
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (stall_tick % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.parse_byte(in_if.rx_byte, in_if.buffer_start);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.kind, out_if.payload_byte, out_if.frame_opcode,
                        out_if.last, out_if.error_code);
    end
  end

  task send_byte(input logic [7:0] b, input logic start);
    int gap;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    in_if.buffer_start <= start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  function void build_frame(input logic [7:0] h0, input logic mbit, input int form,
                            input logic [63:0] dlen, input int npay);
    logic [6:0] len7;
    frame_q.delete();
    frame_q.push_back(h0);
    len7 = (form == 0) ? dlen[6:0] : (form == 1) ? LEN7_EXT16 : LEN7_EXT64;
    frame_q.push_back({mbit, len7});
    if (form == 1) begin
      frame_q.push_back(dlen[15:8]);
      frame_q.push_back(dlen[7:0]);
    end else if (form == 2) begin
      for (int i = 7; i >= 0; i--) frame_q.push_back(dlen[8*i +: 8]);
    end
    repeat (4 + npay) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // keep > 0 cuts the frame to that many bytes when the frame is longer
  task send_frame(input logic [7:0] h0, input logic mbit, input int form,
                  input logic [63:0] dlen, input int npay, input int keep);
    build_frame(h0, mbit, form, dlen, npay);
    if (keep > 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
    foreach (frame_q[i]) send_byte(frame_q[i], i == 0);
  endtask

  task drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task set_max_payload(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.max_payload = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task random_frame();
    int          r;
    int          len;
    int          form;
    logic [3:0]  op;
    logic [63:0] dlen;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      case ($urandom_range(0, 6))
        0, 1: op = OP_TEXT;
        2, 3: op = OP_BINARY;
        4: op = OP_CLOSE;
        5: op = OP_PING;
        default: op = OP_PONG;
      endcase
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
      if (len < 126) begin
        r = $urandom_range(0, 9);
        form = (r < 7) ? 0 : (r < 9) ? 1 : 2;
      end else begin
        form = ($urandom_range(0, 4) == 0) ? 2 : 1;
      end
      dlen = 64'(len);
      if ($urandom_range(0, 9) == 0)
        send_frame({4'h8, op}, 1'b1, form, dlen, len, $urandom_range(1, 6 + len));
      else
        send_frame({4'h8, op}, 1'b1, form, dlen, len, 0);
    end else if (r < 85) begin
      form = $urandom_range(0, 2);
      dlen = (form == 2 && $urandom_range(0, 1)) ? {$urandom, $urandom} :
             64'($urandom_range(0, 30));
      if (form == 0) dlen = 64'($urandom_range(0, 127));
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, dlen,
                 $urandom_range(0, 6), 0);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    int          last_cfg;
    logic [15:0] pick;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    in_if.buffer_start = 1'b0;
    out_if.ready = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    stall_tick = 0;
    burst_left = 4;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed cases
    send_byte(8'hFF, 1'b0);
    send_frame({4'h8, OP_TEXT}, 1'b1, 0, 3, 3, 0);
    send_frame({4'h8, OP_BINARY}, 1'b1, 0, 0, 0, 0);
    send_frame(8'hF1, 1'b1, 0, 2, 2, 0);
    send_frame({4'h8, OP_TEXT}, 1'b0, 0, 2, 2, 0);
    send_frame({4'h0, OP_TEXT}, 1'b1, 0, 2, 2, 0);
    send_frame({4'h8, OP_CONT}, 1'b1, 0, 2, 2, 0);
    send_frame(8'h8F, 1'b1, 0, 2, 2, 0);
    send_frame({4'h8, OP_CLOSE}, 1'b1, 0, 1, 1, 0);
    send_frame({4'h8, OP_CLOSE}, 1'b1, 0, 2, 2, 0);
    send_frame({4'h8, OP_PING}, 1'b1, 1, 126, 0, 0);
    send_frame({4'h8, OP_PONG}, 1'b1, 2, 0, 0, 0);
    send_frame({4'h8, OP_BINARY}, 1'b1, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_frame({4'h8, OP_TEXT}, 1'b1, 2, 2049, 0, 0);
    send_frame({4'h8, OP_TEXT}, 1'b1, 1, 2048, 2, 10);
    send_frame({4'h8, OP_TEXT}, 1'b1, 1, 2049, 0, 0);
    send_frame({4'h8, OP_BINARY}, 1'b1, 0, 4, 4, 1);
    send_frame({4'h8, OP_PING}, 1'b1, 0, 125, 5, 11);
    send_frame({4'h8, OP_BINARY}, 1'b1, 1, 4, 4, 3);
    send_frame({4'h8, OP_TEXT}, 1'b1, 0, 4, 4, 0);
    set_max_payload(16'h0000);
    send_frame({4'h8, OP_TEXT}, 1'b1, 0, 0, 0, 0);
    send_frame({4'h8, OP_TEXT}, 1'b1, 0, 1, 1, 0);
    set_max_payload(16'hFFFF);
    send_frame({4'h8, OP_BINARY}, 1'b1, 1, 65535, 3, 11);
    send_frame({4'h8, OP_BINARY}, 1'b1, 2, 65536, 0, 0);
    set_max_payload(MAX_PAYLOAD_RST);

    // random frames, mostly well formed
    last_cfg = sb.parsed_bytes;
    while (sb.parsed_bytes < 550) begin
      if (sb.parsed_bytes - last_cfg >= 130) begin
        case ($urandom_range(0, 5))
          0: pick = 16'h0000;
          1: pick = 16'hFFFF;
          2: pick = MAX_PAYLOAD_RST;
          3: pick = 16'($urandom_range(1, 40));
          4: pick = 16'($urandom_range(100, 400));
          default: pick = 16'($urandom_range(0, 65535));
        endcase
        set_max_payload(pick);
        last_cfg = sb.parsed_bytes;
      end
      random_frame();
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
